### design/sfrp_pkg.sv
// ----------------------------------------------------------------------------
// sfrp_pkg
// Types and constants shared by the stroke font record parser modules.
// ----------------------------------------------------------------------------
package sfrp_pkg;

	localparam int BYTE_W  = 8;
	localparam int COORD_W = 9;
	localparam int GLYPH_W = 10;
	localparam int KIND_W  = 2;

	// record kinds
	localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POINT  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_TRUNC  = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic signed [COORD_W-1:0] coord_a;
		logic signed [COORD_W-1:0] coord_b;
		logic                      pen_down;
		logic [GLYPH_W-1:0]        glyph_number;
	} sfrp_result_t;

endpackage

### design/sfrp_parse.sv
// ----------------------------------------------------------------------------
// sfrp_parse
// Parser state and the combinational next-state and record logic per byte.
// ----------------------------------------------------------------------------
module sfrp_parse import sfrp_pkg::*; #(
	parameter int unsigned COUNT_DIGITS = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] data_byte,
	output logic              emit,
	output sfrp_result_t      res
);

	localparam logic [2:0] PH_SKIP_HDR = 3'd0;
	localparam logic [2:0] PH_IGNORE   = 3'd1;
	localparam logic [2:0] PH_COUNT    = 3'd2;
	localparam logic [2:0] PH_LEFT     = 3'd3;
	localparam logic [2:0] PH_RIGHT    = 3'd4;
	localparam logic [2:0] PH_SKIP_X   = 3'd5;
	localparam logic [2:0] PH_Y        = 3'd6;
	localparam logic [2:0] PH_DONE     = 3'd7;

	localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
	localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
	localparam logic [2:0]        IGNORE_N = 3'd5;
	localparam logic [2:0]        DIGITS_N = 3'(COUNT_DIGITS);
	localparam logic [9:0]        CNT_MAX  = 10'd1023;

	logic [2:0]         phase_q, phase_d;
	logic [2:0]         fpos_q, fpos_d;
	logic [9:0]         count_q, count_d;
	logic [9:0]         pairs_q, pairs_d;
	logic [BYTE_W-1:0]  held_x_q, held_x_d;
	logic               pen_up_q, pen_up_d;
	logic [COORD_W-1:0] left_q, left_d;
	logic [GLYPH_W-1:0] glyph_q, glyph_d;

	logic [2:0]  fpos_inc;
	logic [3:0]  digit;
	logic [13:0] count_mul;
	logic [9:0]  count_nxt;
	logic [9:0]  pairs_dec;
	logic [COORD_W-1:0] pos_b, pos_x;
	logic        is_marker;

	always_comb begin
		fpos_inc  = fpos_q + 3'd1;
		digit     = 4'(data_byte - CH_ZERO);
		count_mul = {1'b0, count_q, 3'b0} + {3'b0, count_q, 1'b0} + {10'b0, digit};
		if (data_byte >= CH_ZERO && data_byte <= CH_NINE)
			count_nxt = (count_mul > {4'b0, CNT_MAX}) ? CNT_MAX : count_mul[9:0];
		else
			count_nxt = count_q;
		pairs_dec = (pairs_q != 10'd0) ? pairs_q - 10'd1 : 10'd0;
		pos_b     = {1'b0, data_byte} - 9'd82;
		pos_x     = {1'b0, held_x_q} - 9'd82;
		is_marker = !pen_up_q && held_x_q == CH_SPACE && data_byte == CH_R;
	end

	always_comb begin
		phase_d  = phase_q;
		fpos_d   = fpos_q;
		count_d  = count_q;
		pairs_d  = pairs_q;
		held_x_d = held_x_q;
		pen_up_d = pen_up_q;
		left_d   = left_q;
		glyph_d  = glyph_q;
		emit     = 1'b0;
		res.kind         = KIND_HEADER;
		res.coord_a      = '0;
		res.coord_b      = '0;
		res.pen_down     = 1'b0;
		res.glyph_number = glyph_q;

		if (phase_q == PH_DONE) begin
			emit = 1'b0;
		end else if (data_byte == '0) begin
			emit     = 1'b1;
			res.kind = (phase_q == PH_SKIP_HDR) ? KIND_END : KIND_TRUNC;
			phase_d  = PH_DONE;
		end else begin
			unique case (phase_q)
				PH_SKIP_HDR: begin
					if (data_byte != CH_NL) begin
						fpos_d  = 3'd1;
						phase_d = PH_IGNORE;
						count_d = '0;
					end
				end
				PH_IGNORE: begin
					fpos_d = fpos_inc;
					if (fpos_inc >= IGNORE_N) begin
						fpos_d  = '0;
						count_d = '0;
						phase_d = PH_COUNT;
					end
				end
				PH_COUNT: begin
					count_d = count_nxt;
					fpos_d  = fpos_inc;
					if (fpos_inc >= DIGITS_N) begin
						fpos_d  = '0;
						pairs_d = (count_nxt != 10'd0) ? count_nxt - 10'd1 : 10'd0;
						phase_d = PH_LEFT;
					end
				end
				PH_LEFT: begin
					left_d  = pos_b;
					phase_d = PH_RIGHT;
				end
				PH_RIGHT: begin
					emit        = 1'b1;
					res.kind    = KIND_HEADER;
					res.coord_a = left_q;
					res.coord_b = pos_b;
					pen_up_d    = 1'b0;
					if (pairs_q == 10'd0) begin
						glyph_d = (glyph_q != '1) ? glyph_q + 10'd1 : glyph_q;
						phase_d = PH_SKIP_HDR;
					end else begin
						phase_d = PH_SKIP_X;
					end
				end
				PH_SKIP_X: begin
					if (data_byte != CH_NL) begin
						held_x_d = data_byte;
						phase_d  = PH_Y;
					end
				end
				PH_Y: begin
					pairs_d = pairs_dec;
					if (is_marker) begin
						pen_up_d = 1'b1;
						phase_d  = PH_SKIP_X;
					end else begin
						emit         = 1'b1;
						res.kind     = KIND_POINT;
						res.coord_a  = pos_x;
						res.coord_b  = pos_b;
						res.pen_down = !pen_up_q;
						pen_up_d     = 1'b0;
						if (pairs_dec == 10'd0) begin
							glyph_d = (glyph_q != '1) ? glyph_q + 10'd1 : glyph_q;
							phase_d = PH_SKIP_HDR;
						end else begin
							phase_d = PH_SKIP_X;
						end
					end
				end
				default: begin
					phase_d = PH_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SKIP_HDR;
			fpos_q   <= '0;
			count_q  <= '0;
			pairs_q  <= '0;
			held_x_q <= '0;
			pen_up_q <= 1'b0;
			left_q   <= '0;
			glyph_q  <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			fpos_q   <= fpos_d;
			count_q  <= count_d;
			pairs_q  <= pairs_d;
			held_x_q <= held_x_d;
			pen_up_q <= pen_up_d;
			left_q   <= left_d;
			glyph_q  <= glyph_d;
		end
	end

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |-> !emit)
		else $error("record emitted after end of font");

	a_end_between_glyphs: assert property (@(posedge clk) disable iff (!arst_n)
		emit && res.kind == KIND_END |-> phase_q == PH_SKIP_HDR)
		else $error("end of font inside a record");

	a_terminal: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit && (res.kind == KIND_END || res.kind == KIND_TRUNC)
		|=> phase_q == PH_DONE)
		else $error("parser not stopped after terminal record");

	a_pen_only_points: assert property (@(posedge clk) disable iff (!arst_n)
		emit && res.kind != KIND_POINT |-> !res.pen_down)
		else $error("pen down on a non-point record");

endmodule

### design/stroke_font_record_parser.sv
// ----------------------------------------------------------------------------
// stroke_font_record_parser
// Parses a stroke font text stream byte by byte into glyph header, stroke
// point, end of font and truncated record items.
// ----------------------------------------------------------------------------
// a record's byte is held in the input register, then the record in the result register
// throughput: one byte per cycle; the input register and the result register
// each advance whenever the result register is empty or being taken
// bytes that produce no record just update the parser state
// reset clears the parser state, the glyph counter and both valid flags
module stroke_font_record_parser import sfrp_pkg::*; #(
	parameter int unsigned COUNT_DIGITS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [8:0] coord_a, [17:9] coord_b, [18] pen_down,
	                               // [28:19] glyph_number, [31:29] zero
	output logic [1:0]  m_tuser    // [1:0] record_kind
);

	logic [BYTE_W-1:0] byte_s1;
	logic              vld_s1;
	logic              advance;
	logic              emit;
	sfrp_result_t      res;
	sfrp_result_t      res_q;
	logic              out_vld_q;

	assign advance  = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	sfrp_parse #(
		.COUNT_DIGITS (COUNT_DIGITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.emit      (emit),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance && emit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = res_q.kind;
	assign m_tdata  = {3'b0, res_q.glyph_number, res_q.pen_down,
		res_q.coord_b, res_q.coord_a};

endmodule
